[rtl/gelu_pkg.sv]
// package for the gelu half-precision lookup block
// holds the default table size, mode codes, constants and the float conversion functions
// no dependencies
package gelu_pkg;

    localparam int TABLE_ENTRIES_DEF = 65536;
    localparam int MODE_EVAL  = 0;
    localparam int MODE_WRITE = 1;

    localparam logic [31:0] SGL_ABS_MASK = 32'h7fff_ffff;
    localparam logic [31:0] SGL_INF      = 32'h7f80_0000;
    localparam logic [31:0] SGL_TEN      = 32'h4120_0000;
    localparam logic [15:0] HALF_INF     = 16'h7c00;

    // single to half, round half up on magnitude
    function automatic logic [15:0] half_from_single(input logic [31:0] x);
        logic [15:0] sign;
        logic [8:0]  e;
        logic [23:0] man;
        logic [4:0]  sh;
        logic [23:0] r;
        logic [15:0] res;
        sign = {x[31], 15'd0};
        e    = {1'b0, x[30:23]} - 9'd112;
        man  = {1'b0, x[22:0]};
        res  = sign;
        if (e[8] || e == 9'd0) begin
            if ($signed(e) < -9'sd10) begin
                res = sign;
            end else begin
                man = man | 24'h80_0000;
                sh  = 5'(9'd14 - e);
                r   = man >> sh;
                if (man[5'(sh - 5'd1)]) begin
                    r = r + 24'd1;
                end
                res = sign | r[15:0];
            end
        end else if (e >= 9'd31) begin
            res = sign | HALF_INF;
        end else begin
            res = sign | {1'b0, e[4:0], man[22:13]};
            if (man[12]) begin
                res = res + 16'd1;
            end
        end
        return res;
    endfunction

    // half to single, exact
    function automatic logic [31:0] single_from_half(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [19:0] sh;
        logic [31:0] res;
        e   = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        sh  = 20'd0;
        if (e == 5'd0) begin
            if (man == 10'd0) begin
                res = {h[15], 31'd0};
            end else begin
                // leading zero count over ten bits
                for (int i = 0; i < 10; i++) begin
                    if (man[i]) begin
                        lz = 4'(9 - i);
                    end
                end
                sh  = {10'd0, man} << (lz + 4'd1);
                res = {h[15], 8'(8'd113 - 8'd1 - {4'd0, lz}), sh[9:0], 13'd0};
            end
        end else if (e == 5'd31) begin
            res = {h[15], 8'hff, man, 13'd0};
        end else begin
            res = {h[15], 8'({3'd0, e} + 8'd112), man, 13'd0};
        end
        return res;
    endfunction

endpackage

[rtl/gelu_half_precision_lookup.sv]
// top level: gelu by half-precision table lookup
// uses gelu_pkg; table memory is inside this module
//
// channel  dir  fields
// s_axis   in   tdata: mode[0] x_bits[32:1] entry_index[48:33] entry_value[64:49]; tlast
// m_axis   out  tdata: y_bits[31:0]; tlast
//
// one item per cycle while the output is not stalled; results pass the table read, then the output register
// the table read port sets the rate; write items use the same cycle slot
// reset clears the valid flags only; table contents undefined until written
// a stalled output stops input only when both stages are full
module gelu_half_precision_lookup import gelu_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode, x_bits, entry_index, entry_value, zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // y_bits
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [15:0] r_mem [TABLE_ENTRIES];

    logic        in_fire, in_mode;
    logic [31:0] in_x;
    logic [15:0] in_idx, in_val, half;
    logic [31:0] mag;
    logic        nan, neg_big, pos_big;

    assign in_mode = s_axis_tdata[0];
    assign in_x    = s_axis_tdata[32:1];
    assign in_idx  = s_axis_tdata[48:33];
    assign in_val  = s_axis_tdata[64:49];

    // stage 1: read in flight; stage 2: output register
    logic        r_v1, r_v2;
    logic        r_byp1, r_last1, r_last2;
    logic [31:0] r_y1, r_y2;
    logic [15:0] r_rd;
    logic        adv1;

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = r_y2;
    assign m_axis_tlast  = r_last2;

    assign adv1          = r_v1 && (!r_v2 || m_axis_tready);
    assign s_axis_tready = !r_v1 || adv1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // range tests and conversion
    assign mag     = in_x & SGL_ABS_MASK;
    assign nan     = mag > SGL_INF;
    assign neg_big = !nan && in_x[31] && mag >= SGL_TEN;
    assign pos_big = !nan && !in_x[31] && mag >= SGL_TEN;
    assign half    = half_from_single(in_x);

    // table memory, one write or one read per item
    always_ff @(posedge i_clk) begin
        if (in_fire && in_mode == 1'(MODE_WRITE)) begin
            r_mem[in_idx[AW-1:0]] <= in_val;
        end else if (in_fire) begin
            r_rd <= r_mem[half[AW-1:0]];
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byp1  <= neg_big || pos_big;
            r_y1    <= pos_big ? in_x : 32'd0;
            r_last1 <= s_axis_tlast;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_y2    <= r_byp1 ? r_y1 : single_from_half(r_rd);
            r_last2 <= r_last1;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (in_fire) begin
                r_v1 <= in_mode == 1'(MODE_EVAL);
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (m_axis_tready) begin
                r_v2 <= 1'b0;
            end
        end
    end

endmodule
